// ===== hdl/md5_pkg.sv =====
// shared types, constants and helper functions for the md5 engine
package md5_pkg;

  typedef logic [3:0][31:0] md5_words_t;

  typedef struct packed {
    logic load;
    logic step;
  } md5_rnd_ctl_t;

  typedef struct packed {
    logic       last;
    logic [3:0] m_addr;
  } md5_rnd_sts_t;

  localparam md5_words_t MD5_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;
  localparam logic [5:0] MD5_LAST_POS = 6'd63;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index used by a round
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] g;
    lo = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = lo;
      2'd1: g = 4'(lo * 4'd5 + 4'd1);
      2'd2: g = 4'(lo * 4'd3 + 4'd5);
      2'd3: g = 4'(lo * 4'd7);
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

// ===== hdl/md5_ifs.sv =====
// valid/ready channel interfaces for message bytes and digests
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output byte_value, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input byte_value, input byte_present,
                  input end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_a;
  logic [31:0] digest_word_b;
  logic [31:0] digest_word_c;
  logic [31:0] digest_word_d;

  modport source (output valid, output digest_word_a, output digest_word_b,
                  output digest_word_c, output digest_word_d, input ready);
  modport sink   (input valid, input digest_word_a, input digest_word_b,
                  input digest_word_c, input digest_word_d, output ready);
endinterface

// ===== hdl/md5_buf.sv =====
// 64-byte block buffer: byte writes, registered 32-bit word reads
module md5_buf (
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [7:0]  wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [16];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[5:2]][{waddr[1:0], 3'b000} +: 8] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/md5_round.sv =====
// md5 round unit: working words and round counter, one round per step
module md5_round
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  md5_rnd_ctl_t ctl,
  input  md5_words_t   chain_in,
  input  logic [31:0]  m_word,
  output md5_words_t   words,
  output md5_rnd_sts_t sts
);

  md5_words_t  w_r;
  md5_words_t  w_nxt;
  logic [5:0]  rnd_r;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (w_r[1] & w_r[2]) | (~w_r[1] & w_r[3]);
      2'd1: f = (w_r[3] & w_r[1]) | (~w_r[3] & w_r[2]);
      2'd2: f = w_r[1] ^ w_r[2] ^ w_r[3];
      2'd3: f = w_r[2] ^ (w_r[1] | ~w_r[3]);
      default: f = '0;
    endcase
    sum = w_r[0] + f + MD5_K[rnd_r] + m_word;
    rot = md5_rotl(sum, MD5_ROT[{rnd_r[5:4], rnd_r[1:0]}]);
    w_nxt[0] = w_r[3];
    w_nxt[1] = w_r[1] + rot;
    w_nxt[2] = w_r[1];
    w_nxt[3] = w_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (ctl.load) begin
      rnd_r <= '0;
    end else if (ctl.step) begin
      rnd_r <= rnd_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      w_r <= chain_in;
    end else if (ctl.step) begin
      w_r <= w_nxt;
    end
  end

  // prefetch the message word for the following round
  assign sts.m_addr = ctl.load ? 4'd0 : md5_g(rnd_r + 6'd1);
  assign sts.last   = (rnd_r == 6'd63);
  assign words      = w_r;

endmodule

// ===== hdl/md5_hash_engine.sv =====
// md5 hash engine top level: byte intake, padding sequencer and chaining words
//
// Takes up to one message byte per beat and returns the 128-bit MD5 digest as
// four little-endian words after a beat flagged end of message. A byte beat is
// taken only while the block sits idle. The 64th byte of a block starts a
// compression on the single round unit (a load that prefetches the first word,
// 64 rounds, one chaining add) during which no byte is taken. The end of
// message writes the 0x80 marker, zero bytes and eight length bytes into the
// buffer at one byte per cycle, but not while a full block is compressed, runs
// one or two compressions and a finish state that hands the digest to the
// output register once it is free; the next message may start while that
// digest still waits to be taken.
module md5_hash_engine
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD80 = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_COMP  = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  cnt_r, cnt_nxt;
  md5_words_t   chain_r, chain_nxt;
  logic         pad_r, pad_nxt;
  logic         p80_r, p80_nxt;
  logic         len_r, len_nxt;
  logic         done_r, done_nxt;
  logic         out_valid_r, out_valid_nxt;
  md5_words_t   out_words_r, out_words_nxt;

  logic         in_accept;
  logic         out_accept;
  logic         buf_we;
  logic [7:0]   buf_wdata;
  logic [31:0]  buf_rdata;
  logic         len_sel;
  logic [63:0]  bit_len;
  logic [7:0]   len_byte;
  md5_rnd_ctl_t rnd_ctl;
  md5_rnd_sts_t rnd_sts;
  md5_words_t   rnd_words;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_accept  = out_valid_r && out_ch.ready;

  assign bit_len  = {cnt_r, 3'b000};
  assign len_byte = bit_len[{fill_r[2:0], 3'b000} +: 8];
  assign len_sel  = len_r || (fill_r == MD5_LEN_POS);

  md5_buf u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (fill_r),
    .wdata (buf_wdata),
    .raddr (rnd_sts.m_addr),
    .rdata (buf_rdata)
  );

  md5_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rnd_ctl),
    .chain_in (chain_r),
    .m_word   (buf_rdata),
    .words    (rnd_words),
    .sts      (rnd_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    chain_nxt     = chain_r;
    pad_nxt       = pad_r;
    p80_nxt       = p80_r;
    len_nxt       = len_r;
    done_nxt      = done_r;
    out_words_nxt = out_words_r;
    out_valid_nxt = out_valid_r && !out_accept;
    buf_we        = 1'b0;
    buf_wdata     = 8'h00;
    rnd_ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.byte_present) begin
            buf_we    = 1'b1;
            buf_wdata = in_ch.byte_value;
            cnt_nxt   = cnt_r + 61'd1;
            fill_nxt  = fill_r + 6'd1;
            if (fill_r == MD5_LAST_POS) begin
              state_nxt = ST_LOAD;
              pad_nxt   = in_ch.end_of_message;
            end else if (in_ch.end_of_message) begin
              state_nxt = ST_PAD80;
            end
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        buf_we    = 1'b1;
        buf_wdata = MD5_PAD_BYTE;
        fill_nxt  = fill_r + 6'd1;
        p80_nxt   = 1'b1;
        state_nxt = (fill_r == MD5_LAST_POS) ? ST_LOAD : ST_PAD;
      end
      ST_PAD: begin
        // zeros until offset 56, then the little-endian bit length
        buf_we    = 1'b1;
        buf_wdata = len_sel ? len_byte : 8'h00;
        len_nxt   = len_sel;
        fill_nxt  = fill_r + 6'd1;
        if (fill_r == MD5_LAST_POS) begin
          state_nxt = ST_LOAD;
          done_nxt  = len_sel;
        end
      end
      ST_LOAD: begin
        rnd_ctl.load = 1'b1;
        state_nxt    = ST_COMP;
      end
      ST_COMP: begin
        rnd_ctl.step = 1'b1;
        if (rnd_sts.last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + rnd_words[i];
        end
        priority if (done_r) begin
          state_nxt = ST_FIN;
        end else if (p80_r) begin
          state_nxt = ST_PAD;
        end else if (pad_r) begin
          state_nxt = ST_PAD80;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_accept) begin
          out_words_nxt = chain_r;
          out_valid_nxt = 1'b1;
          chain_nxt     = MD5_INIT;
          cnt_nxt       = '0;
          fill_nxt      = '0;
          pad_nxt       = 1'b0;
          p80_nxt       = 1'b0;
          len_nxt       = 1'b0;
          done_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      chain_r     <= MD5_INIT;
      pad_r       <= 1'b0;
      p80_r       <= 1'b0;
      len_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      chain_r     <= chain_nxt;
      pad_r       <= pad_nxt;
      p80_r       <= p80_nxt;
      len_r       <= len_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_words_r <= out_words_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.digest_word_a = out_words_r[0];
  assign out_ch.digest_word_b = out_words_r[1];
  assign out_ch.digest_word_c = out_words_r[2];
  assign out_ch.digest_word_d = out_words_r[3];

  a_last_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_sts.last) |=> (state_r == ST_ADD))
    else $error("compression did not end after the last round");

  a_len_starts_at_56: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(len_r) |-> (fill_r == 6'd57))
    else $error("length bytes did not start at offset 56");

  a_final_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (fill_r == 6'd0 && len_r))
    else $error("digest finish with a partly filled block");

  a_count_held_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD || state_r == ST_COMP) |=> $stable(cnt_r))
    else $error("byte count changed while padding or compressing");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for md5_hash_engine: directed digests, then random messages
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_BEATS = 1100;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  typedef struct {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       end_of_message;
    bit         typed;
    digest_t    digest;
  } stim_row_t;

  // well known digests, words little-endian
  localparam digest_t DIGEST_EMPTY =
    {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
  localparam digest_t DIGEST_A =
    {32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769};
  localparam digest_t DIGEST_ABC =
    {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};
  localparam digest_t NO_DIGEST = '0;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic clk;
  logic rst_n;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_hash_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [31:0] md5_chain [4];
  logic [7:0]  msg_bytes [64];
  int          msg_fill;
  logic [63:0] msg_bits;

  digest_t digest_queue [$];
  int      fails = 0;
  int      cycles = 0;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      hold_req;

  stim_row_t directed_rows [15];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void md5_restart();
    md5_chain[0] = 32'h67452301;
    md5_chain[1] = 32'hefcdab89;
    md5_chain[2] = 32'h98badcfe;
    md5_chain[3] = 32'h10325476;
    msg_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void md5_compress_block();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, s;
    for (int i = 0; i < 16; i++)
      m[i] = {msg_bytes[4*i+3], msg_bytes[4*i+2], msg_bytes[4*i+1], msg_bytes[4*i]};
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = ROUND_SHIFT[(i / 16) * 4 + i % 4];
      sum = a + f + ROUND_K[i] + m[g];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  function automatic void md5_absorb_byte(input logic [7:0] value);
    msg_bytes[msg_fill] = value;
    msg_fill++;
    if (msg_fill == 64) begin
      md5_compress_block();
      msg_fill = 0;
    end
  endfunction

  // returns 1 when the beat closes a message, with its digest
  function automatic bit md5_predict_beat(input logic [7:0] value, input logic present,
                                          input logic last, output digest_t dig);
    logic [63:0] bits;
    dig = '0;
    if (present) begin
      msg_bits += 64'd8;
      md5_absorb_byte(value);
    end
    if (!last) return 1'b0;
    bits = msg_bits;
    md5_absorb_byte(8'h80);
    while (msg_fill != 56) md5_absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) md5_absorb_byte(bits[8*i +: 8]);
    dig = {md5_chain[0], md5_chain[1], md5_chain[2], md5_chain[3]};
    md5_restart();
    return 1'b1;
  endfunction

  // entered and left at a falling edge; valid stays up for a following beat
  task automatic send_beat(input logic [7:0] value, input logic present, input logic last,
                           input bit typed, input digest_t typed_digest);
    digest_t dig;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.byte_value     <= value;
    in_ch.byte_present   <= present;
    in_ch.end_of_message <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (md5_predict_beat(value, present, last, dig))
      digest_queue.push_back(typed ? typed_digest : dig);
    @(negedge clk);
  endtask

  task automatic wait_all_digests();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (digest_queue.size() != 0);
  endtask

  function automatic int pick_length();
    int boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return boundary[$urandom_range(9)];
    if (roll < 44) return $urandom_range(300, 200);
    return $urandom_range(100);
  endfunction

  // stimulus
  initial begin
    int sent;
    int len;
    bit bare_end;
    in_ch.valid          = 1'b0;
    in_ch.byte_value     = '0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    rst_n       = 1'b0;
    hold_req    = 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 78;
    md5_restart();

    directed_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // bare beat, no effect
      '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},  // empty message
      '{8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A},      // byte carried with the end flag
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // bare beat inside a message
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},    // bare end after the last byte
      '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},  // restart right after a digest
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].byte_value, directed_rows[i].byte_present,
                directed_rows[i].end_of_message, directed_rows[i].typed,
                directed_rows[i].digest);
    wait_all_digests();

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      if (sent >= 2 * RANDOM_BEATS / 3 && tx_idle_pct != 0) begin
        // no idling from here on, and one long stall on the digest side
        wait_all_digests();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end else if (sent >= RANDOM_BEATS / 3 && tx_idle_pct == 11) begin
        wait_all_digests();
        tx_idle_pct = 78;
        rx_idle_pct = 11;
      end
      len = pick_length();
      bare_end = (len == 0) || ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
        // occasional bare beats as noise
        if ($urandom_range(99) < 4)
          send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
        send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !bare_end,
                  1'b0, NO_DIGEST);
        sent++;
      end
      if (bare_end) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        sent++;
      end
    end

    wait_all_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && digest_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // digest side ready, with one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_digest_word(input string name, input logic [31:0] expected,
                                            input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %h, got %h", name, expected, actual);
      fails++;
    end
  endfunction

  // digest beat checker
  always @(posedge clk) begin
    digest_t exp_digest;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_queue.size() == 0) begin
        $error("digest beat with nothing expected: %h %h %h %h", out_ch.digest_word_a,
               out_ch.digest_word_b, out_ch.digest_word_c, out_ch.digest_word_d);
        fails++;
      end else begin
        exp_digest = digest_queue.pop_front();
        check_digest_word("digest_word_a", exp_digest.a, out_ch.digest_word_a);
        check_digest_word("digest_word_b", exp_digest.b, out_ch.digest_word_b);
        check_digest_word("digest_word_c", exp_digest.c, out_ch.digest_word_c);
        check_digest_word("digest_word_d", exp_digest.d, out_ch.digest_word_d);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/md5_pkg.sv
hdl/md5_ifs.sv
hdl/md5_buf.sv
hdl/md5_round.sv
hdl/md5_hash_engine.sv
tb/tb.sv
